FILE: hdl/cpd_pkg.sv
// Shared types, constants and codes for the CRC packet deframer.
`default_nettype none
package cpd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CRC_W-1:0] CRC_INIT  = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY  = 16'hA001;
  localparam logic [LEN_W-1:0] LEN_EXTRA = 16'd9;

  localparam logic [BYTE_W-1:0] HEAD_BYTE_RST   = 8'h50;
  localparam logic [BYTE_W-1:0] TAIL_BYTE_RST   = 8'h43;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'd1024;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_OK         = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_HEADER = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_CRC    = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_TAIL   = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_LENGTH = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] head_byte;
    logic [BYTE_W-1:0] tail_byte;
    logic [LEN_W-1:0]  max_payload;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hdl/cpd_if.sv
// Valid/ready channel interfaces for received bytes and deframer results.
`default_nettype none
interface cpd_in_if;
  logic                          valid;
  logic                          ready;
  logic [cpd_pkg::BYTE_W-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cpd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [cpd_pkg::BYTE_W-1:0]    payload_byte;
  logic [cpd_pkg::BYTE_W-1:0]    frame_order;
  logic [cpd_pkg::LEN_W-1:0]     payload_length;
  logic [cpd_pkg::VERDICT_W-1:0] verdict;

  modport source (output valid, output kind, output payload_byte, output frame_order,
                  output payload_length, output verdict, input ready);
  modport sink   (input valid, input kind, input payload_byte, input frame_order,
                  input payload_length, input verdict, output ready);
endinterface
`default_nettype wire

FILE: hdl/cpd_cfg_regs.sv
// Configuration registers: header byte, tail byte and payload length limit.
`default_nettype none
module cpd_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [cpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cpd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output cpd_pkg::cfg_t                          cfg
);

  cpd_pkg::cfg_t cfg_r;
  cpd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        cpd_pkg::CFG_HEAD_BYTE:   cfg_nxt.head_byte   = cfg_data[cpd_pkg::BYTE_W-1:0];
        cpd_pkg::CFG_TAIL_BYTE:   cfg_nxt.tail_byte   = cfg_data[cpd_pkg::BYTE_W-1:0];
        cpd_pkg::CFG_MAX_PAYLOAD: cfg_nxt.max_payload = cfg_data[cpd_pkg::LEN_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_byte   <= cpd_pkg::HEAD_BYTE_RST;
      cfg_r.tail_byte   <= cpd_pkg::TAIL_BYTE_RST;
      cfg_r.max_payload <= cpd_pkg::MAX_PAYLOAD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: hdl/cpd_crc_step.sv
// One-byte CRC-16/MODBUS update, reflected, unrolled over the eight bits.
`default_nettype none
module cpd_crc_step (
  input  wire logic [cpd_pkg::CRC_W-1:0]  crc_in,
  input  wire logic [cpd_pkg::BYTE_W-1:0] data_in,
  output logic      [cpd_pkg::CRC_W-1:0]  crc_out
);

  always_comb begin
    logic [cpd_pkg::CRC_W-1:0] c;
    c = crc_in ^ {{(cpd_pkg::CRC_W-cpd_pkg::BYTE_W){1'b0}}, data_in};
    for (int k = 0; k < cpd_pkg::BYTE_W; k++) begin
      if (c[0]) c = (c >> 1) ^ cpd_pkg::CRC_POLY;
      else      c = c >> 1;
    end
    crc_out = c;
  end

endmodule
`default_nettype wire

FILE: hdl/crc_packet_deframer_core.sv
// Frame checker: an accepted byte's result is in the output register in the next cycle.
// Throughput: one byte per cycle when not stalled; state and byte-wide CRC update together.
// in ready is low only while the output register holds a result that is not being taken.
// Bytes that produce no result (header, length, order, CRC, first tail) leave no output.
// Reset (rst_n, synchronous, active low) returns to header hunt, CRC 0xFFFF, default config.
`default_nettype none
module crc_packet_deframer_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  cpd_in_if.sink                              in_ch,
  cpd_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    PH_HEAD1 = 4'd0,
    PH_HEAD2 = 4'd1,
    PH_LENH  = 4'd2,
    PH_LENL  = 4'd3,
    PH_ORDER = 4'd4,
    PH_DATA  = 4'd5,
    PH_CRCH  = 4'd6,
    PH_CRCL  = 4'd7,
    PH_TAIL1 = 4'd8,
    PH_TAIL2 = 4'd9
  } phase_t;

  function automatic logic [cpd_pkg::LEN_W-1:0] pay_len(input logic [cpd_pkg::LEN_W-1:0] len);
    return (len >= cpd_pkg::LEN_EXTRA) ? len - cpd_pkg::LEN_EXTRA : '0;
  endfunction

  cpd_pkg::cfg_t cfg;

  cpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  phase_t                       phase_r,        phase_nxt;
  logic [cpd_pkg::LEN_W-1:0]    bytes_left_r,   bytes_left_nxt;
  logic [cpd_pkg::LEN_W-1:0]    frame_len_r,    frame_len_nxt;
  logic [cpd_pkg::BYTE_W-1:0]   order_r,        order_nxt;
  logic [cpd_pkg::CRC_W-1:0]    crc_r,          crc_nxt;
  logic [cpd_pkg::BYTE_W-1:0]   crc_high_r,     crc_high_nxt;
  logic                         crc_failed_r,   crc_failed_nxt;
  logic                         tail_failed_r,  tail_failed_nxt;

  logic                         out_valid_r,    out_valid_nxt;
  logic                         kind_r,         kind_nxt;
  logic [cpd_pkg::BYTE_W-1:0]   pbyte_r,        pbyte_nxt;
  logic [cpd_pkg::BYTE_W-1:0]   forder_r,       forder_nxt;
  logic [cpd_pkg::LEN_W-1:0]    plen_r,         plen_nxt;
  logic [cpd_pkg::VERDICT_W-1:0] verdict_r,     verdict_nxt;

  logic                         accept;
  logic                         res_valid;
  logic [cpd_pkg::BYTE_W-1:0]   b;
  logic [cpd_pkg::CRC_W-1:0]    crc_upd;
  logic [cpd_pkg::LEN_W-1:0]    new_len;
  logic [cpd_pkg::LEN_W-1:0]    new_plen;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign new_len     = {frame_len_r[cpd_pkg::LEN_W-1:cpd_pkg::BYTE_W], b};
  assign new_plen    = pay_len(new_len);

  cpd_crc_step u_crc (
    .crc_in  (crc_r),
    .data_in (b),
    .crc_out (crc_upd)
  );

  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    frame_len_nxt   = frame_len_r;
    order_nxt       = order_r;
    crc_nxt         = crc_r;
    crc_high_nxt    = crc_high_r;
    crc_failed_nxt  = crc_failed_r;
    tail_failed_nxt = tail_failed_r;
    res_valid       = 1'b0;
    kind_nxt        = kind_r;
    pbyte_nxt       = pbyte_r;
    forder_nxt      = forder_r;
    plen_nxt        = plen_r;
    verdict_nxt     = verdict_r;

    if (accept) begin
      case (phase_r)
        PH_HEAD2: begin
          if (b == cfg.head_byte) begin
            phase_nxt = PH_LENH;
          end else begin
            phase_nxt   = PH_HEAD1;
            res_valid   = 1'b1;
            kind_nxt    = cpd_pkg::KIND_STATUS;
            pbyte_nxt   = '0;
            forder_nxt  = '0;
            plen_nxt    = '0;
            verdict_nxt = cpd_pkg::VERDICT_BAD_HEADER;
          end
        end
        PH_LENH: begin
          frame_len_nxt = {b, {cpd_pkg::BYTE_W{1'b0}}};
          phase_nxt     = PH_LENL;
        end
        PH_LENL: begin
          frame_len_nxt = new_len;
          if (new_len < cpd_pkg::LEN_EXTRA || new_plen > cfg.max_payload) begin
            phase_nxt   = PH_HEAD1;
            res_valid   = 1'b1;
            kind_nxt    = cpd_pkg::KIND_STATUS;
            pbyte_nxt   = '0;
            forder_nxt  = '0;
            plen_nxt    = new_plen;
            verdict_nxt = cpd_pkg::VERDICT_BAD_LENGTH;
          end else begin
            phase_nxt = PH_ORDER;
          end
        end
        PH_ORDER: begin
          order_nxt       = b;
          crc_nxt         = cpd_pkg::CRC_INIT;
          crc_failed_nxt  = 1'b0;
          tail_failed_nxt = 1'b0;
          bytes_left_nxt  = pay_len(frame_len_r);
          // Empty payload goes straight to the CRC bytes
          phase_nxt       = (pay_len(frame_len_r) != '0) ? PH_DATA : PH_CRCH;
        end
        PH_DATA: begin
          crc_nxt        = crc_upd;
          bytes_left_nxt = bytes_left_r - 1'b1;
          if (bytes_left_r == 16'd1) phase_nxt = PH_CRCH;
          res_valid   = 1'b1;
          kind_nxt    = cpd_pkg::KIND_PAYLOAD;
          pbyte_nxt   = b;
          forder_nxt  = order_r;
          plen_nxt    = pay_len(frame_len_r);
          verdict_nxt = cpd_pkg::VERDICT_OK;
        end
        PH_CRCH: begin
          crc_high_nxt = b;
          phase_nxt    = PH_CRCL;
        end
        PH_CRCL: begin
          crc_failed_nxt = (crc_high_r != crc_r[cpd_pkg::CRC_W-1:cpd_pkg::BYTE_W]) ||
                           (b != crc_r[cpd_pkg::BYTE_W-1:0]);
          phase_nxt      = PH_TAIL1;
        end
        PH_TAIL1: begin
          tail_failed_nxt = (b != cfg.tail_byte);
          phase_nxt       = PH_TAIL2;
        end
        PH_TAIL2: begin
          tail_failed_nxt = tail_failed_r || (b != cfg.tail_byte);
          phase_nxt       = PH_HEAD1;
          res_valid       = 1'b1;
          kind_nxt        = cpd_pkg::KIND_STATUS;
          pbyte_nxt       = '0;
          forder_nxt      = order_r;
          plen_nxt        = pay_len(frame_len_r);
          // CRC failure takes precedence over a bad tail
          if (crc_failed_r)
            verdict_nxt = cpd_pkg::VERDICT_BAD_CRC;
          else if (tail_failed_r || (b != cfg.tail_byte))
            verdict_nxt = cpd_pkg::VERDICT_BAD_TAIL;
          else
            verdict_nxt = cpd_pkg::VERDICT_OK;
        end
        default: begin
          // Hunt: drop bytes until a first header byte shows up
          phase_nxt = (b == cfg.head_byte) ? PH_HEAD2 : PH_HEAD1;
        end
      endcase
    end

    if (res_valid)         out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEAD1;
      bytes_left_r  <= '0;
      frame_len_r   <= '0;
      order_r       <= '0;
      crc_r         <= cpd_pkg::CRC_INIT;
      crc_high_r    <= '0;
      crc_failed_r  <= 1'b0;
      tail_failed_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      frame_len_r   <= frame_len_nxt;
      order_r       <= order_nxt;
      crc_r         <= crc_nxt;
      crc_high_r    <= crc_high_nxt;
      crc_failed_r  <= crc_failed_nxt;
      tail_failed_r <= tail_failed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result payload: load only on a new result
  always_ff @(posedge clk) begin
    if (res_valid) begin
      kind_r    <= kind_nxt;
      pbyte_r   <= pbyte_nxt;
      forder_r  <= forder_nxt;
      plen_r    <= plen_nxt;
      verdict_r <= verdict_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.payload_byte   = pbyte_r;
  assign out_ch.frame_order    = forder_r;
  assign out_ch.payload_length = plen_r;
  assign out_ch.verdict        = verdict_r;

endmodule
`default_nettype wire

FILE: tb/tb_crc_packet_deframer_core.sv
// Self-checking testbench for crc_packet_deframer_core: directed and random frame streams.
module tb_crc_packet_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef enum logic [3:0] {
    ST_HEAD1, ST_HEAD2, ST_LEN_HI, ST_LEN_LO, ST_ORDER,
    ST_DATA, ST_CRC_HI, ST_CRC_LO, ST_TAIL1, ST_TAIL2
  } frame_state_e;

  typedef enum logic [2:0] {
    FRAME_GOOD, FRAME_BAD_CRC, FRAME_BAD_TAIL, FRAME_BAD_BOTH,
    FRAME_BAD_HEAD, FRAME_SHORT_LEN, FRAME_LONG_LEN, FRAME_CUT
  } frame_fault_e;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_MOSTLY} ready_mode_e;

  typedef struct packed {
    logic                 kind;
    logic [BYTE_W-1:0]    payload_byte;
    logic [BYTE_W-1:0]    frame_order;
    logic [LEN_W-1:0]     payload_length;
    logic [VERDICT_W-1:0] verdict;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cpd_in_if  in_ch();
  cpd_out_if out_ch();

  crc_packet_deframer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Deframer state as the checker sees it
  cfg_t              model_cfg;
  frame_state_e      fr_state;
  logic [LEN_W-1:0]  fr_left;
  logic [LEN_W-1:0]  fr_length;
  logic [BYTE_W-1:0] fr_order;
  logic [BYTE_W-1:0] fr_crc_hi;
  logic [CRC_W-1:0]  fr_crc;
  logic              fr_crc_bad;
  logic              fr_tail_bad;

  result_t           expected_results[$];
  logic [BYTE_W-1:0] byte_queue[$];
  int unsigned       bytes_queued;
  int unsigned       bytes_taken;
  int unsigned       error_count;
  int unsigned       cycle_count;
  int unsigned       burst_left;
  int unsigned       gap_left;
  ready_mode_e       ready_mode;
  int unsigned       ready_span;
  result_t           due_result;
  result_t           seen_result;

  always #10 clk = ~clk;

  function automatic logic [CRC_W-1:0] crc16_next(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] net_payload(logic [LEN_W-1:0] total);
    return (total >= LEN_EXTRA) ? total - LEN_EXTRA : '0;
  endfunction

  function automatic void reset_deframer();
    model_cfg.head_byte   = HEAD_BYTE_RST;
    model_cfg.tail_byte   = TAIL_BYTE_RST;
    model_cfg.max_payload = MAX_PAYLOAD_RST;
    fr_state    = ST_HEAD1;
    fr_left     = '0;
    fr_length   = '0;
    fr_order    = '0;
    fr_crc_hi   = '0;
    fr_crc      = CRC_INIT;
    fr_crc_bad  = 1'b0;
    fr_tail_bad = 1'b0;
  endfunction

  // Advance the frame state by one received byte; queue the result it causes, if any.
  function automatic void deframe_byte(logic [BYTE_W-1:0] b);
    result_t r;
    r = '0;
    case (fr_state)
      ST_HEAD2: begin
        if (b == model_cfg.head_byte) begin
          fr_state = ST_LEN_HI;
        end else begin
          fr_state = ST_HEAD1;
          r.kind = KIND_STATUS;
          r.verdict = VERDICT_BAD_HEADER;
          expected_results.push_back(r);
        end
      end
      ST_LEN_HI: begin
        fr_length = {b, 8'h00};
        fr_state = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        fr_length = {fr_length[15:8], b};
        if (fr_length < LEN_EXTRA || net_payload(fr_length) > model_cfg.max_payload) begin
          fr_state = ST_HEAD1;
          r.kind = KIND_STATUS;
          r.payload_length = net_payload(fr_length);
          r.verdict = VERDICT_BAD_LENGTH;
          expected_results.push_back(r);
        end else begin
          fr_state = ST_ORDER;
        end
      end
      ST_ORDER: begin
        fr_order = b;
        fr_crc = CRC_INIT;
        fr_crc_bad = 1'b0;
        fr_tail_bad = 1'b0;
        fr_left = net_payload(fr_length);
        fr_state = (fr_left != 0) ? ST_DATA : ST_CRC_HI;
      end
      ST_DATA: begin
        fr_crc = crc16_next(fr_crc, b);
        fr_left = fr_left - 1'b1;
        if (fr_left == 0) fr_state = ST_CRC_HI;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        r.frame_order = fr_order;
        r.payload_length = net_payload(fr_length);
        r.verdict = VERDICT_OK;
        expected_results.push_back(r);
      end
      ST_CRC_HI: begin
        fr_crc_hi = b;
        fr_state = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        fr_crc_bad = ({fr_crc_hi, b} != fr_crc);
        fr_state = ST_TAIL1;
      end
      ST_TAIL1: begin
        fr_tail_bad = (b != model_cfg.tail_byte);
        fr_state = ST_TAIL2;
      end
      ST_TAIL2: begin
        fr_tail_bad = fr_tail_bad || (b != model_cfg.tail_byte);
        fr_state = ST_HEAD1;
        r.kind = KIND_STATUS;
        r.frame_order = fr_order;
        r.payload_length = net_payload(fr_length);
        // a CRC error outranks a tail error
        r.verdict = fr_crc_bad ? VERDICT_BAD_CRC : (fr_tail_bad ? VERDICT_BAD_TAIL : VERDICT_OK);
        expected_results.push_back(r);
      end
      default: fr_state = (b == model_cfg.head_byte) ? ST_HEAD2 : ST_HEAD1;
    endcase
  endfunction

  function automatic void send_byte(logic [BYTE_W-1:0] b);
    byte_queue.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void send_length_probe(logic [LEN_W-1:0] total);
    send_byte(model_cfg.head_byte);
    send_byte(model_cfg.head_byte);
    send_byte(total[15:8]);
    send_byte(total[7:0]);
  endfunction

  function automatic void send_frame(frame_fault_e fault, int unsigned n,
                                     logic [BYTE_W-1:0] order);
    logic [BYTE_W-1:0] frame[$];
    logic [CRC_W-1:0]  crc;
    logic [LEN_W-1:0]  total;
    logic [BYTE_W-1:0] pb;
    logic [BYTE_W-1:0] t1;
    logic [BYTE_W-1:0] t2;
    logic [1:0]        wrong;
    int unsigned       keep;
    int unsigned       lo;
    case (fault)
      FRAME_BAD_HEAD: begin
        send_byte(model_cfg.head_byte);
        send_byte(model_cfg.head_byte ^ 8'($urandom_range(1, 255)));
        return;
      end
      FRAME_SHORT_LEN: begin
        send_length_probe(16'($urandom_range(0, 8)));
        return;
      end
      FRAME_LONG_LEN: begin
        lo = model_cfg.max_payload + 10;
        send_length_probe(16'($urandom_range(lo, 65535)));
        return;
      end
      default: ;
    endcase
    total = 16'(n + LEN_EXTRA);
    crc = CRC_INIT;
    frame.push_back(model_cfg.head_byte);
    frame.push_back(model_cfg.head_byte);
    frame.push_back(total[15:8]);
    frame.push_back(total[7:0]);
    frame.push_back(order);
    repeat (n) begin
      pb = 8'($urandom);
      crc = crc16_next(crc, pb);
      frame.push_back(pb);
    end
    if (fault == FRAME_BAD_CRC || fault == FRAME_BAD_BOTH)
      crc = crc ^ 16'($urandom_range(1, 65535));
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
    t1 = model_cfg.tail_byte;
    t2 = model_cfg.tail_byte;
    if (fault == FRAME_BAD_TAIL || fault == FRAME_BAD_BOTH) begin
      wrong = 2'($urandom_range(1, 3));
      if (wrong[0]) t1 = t1 ^ 8'($urandom_range(1, 255));
      if (wrong[1]) t2 = t2 ^ 8'($urandom_range(1, 255));
    end
    frame.push_back(t1);
    frame.push_back(t2);
    keep = (fault == FRAME_CUT) ? $urandom_range(1, frame.size() - 1) : frame.size();
    for (int i = 0; i < keep; i++) send_byte(frame[i]);
  endfunction

  // Mostly short payloads, now and then one up to 200 bytes, never over the limit.
  function automatic int unsigned pick_payload_len();
    int unsigned cap;
    cap = (model_cfg.max_payload < 16) ? model_cfg.max_payload : 16;
    if ($urandom_range(0, 7) == 0)
      cap = (model_cfg.max_payload < 200) ? model_cfg.max_payload : 200;
    return $urandom_range(0, cap);
  endfunction

  // Tidy streams leave the deframer hunting after every frame: no cut frames, and
  // line noise never holds the header byte.
  function automatic void random_traffic(int unsigned budget, bit tidy);
    int unsigned sent;
    int unsigned pick;
    int unsigned mark;
    logic [BYTE_W-1:0] junk;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      mark = bytes_queued;
      if (pick < 60) begin
        send_frame(FRAME_GOOD, pick_payload_len(), 8'($urandom));
      end else if (pick < 68) begin
        send_frame(FRAME_BAD_CRC, pick_payload_len(), 8'($urandom));
      end else if (pick < 74) begin
        send_frame(FRAME_BAD_TAIL, pick_payload_len(), 8'($urandom));
      end else if (pick < 78) begin
        send_frame(FRAME_BAD_BOTH, pick_payload_len(), 8'($urandom));
      end else if (pick < 84) begin
        send_frame(FRAME_BAD_HEAD, 0, 8'h00);
      end else if (pick < 88) begin
        send_frame(FRAME_SHORT_LEN, 0, 8'h00);
      end else if (pick < 92 && model_cfg.max_payload < 16'd65526) begin
        send_frame(FRAME_LONG_LEN, 0, 8'h00);
      end else if (pick < 96 && !tidy) begin
        send_frame(FRAME_CUT, pick_payload_len(), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          junk = 8'($urandom);
          if (tidy && junk == model_cfg.head_byte) junk = junk ^ 8'h01;
          send_byte(junk);
        end
        mark = bytes_queued;
      end
      sent += bytes_queued - mark;
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_HEAD_BYTE:   model_cfg.head_byte = data[BYTE_W-1:0];
      CFG_TAIL_BYTE:   model_cfg.tail_byte = data[BYTE_W-1:0];
      CFG_MAX_PAYLOAD: model_cfg.max_payload = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(logic [BYTE_W-1:0] head, logic [BYTE_W-1:0] tail,
                                logic [LEN_W-1:0] max_len);
    write_reg(CFG_HEAD_BYTE, {8'h00, head});
    write_reg(CFG_TAIL_BYTE, {8'h00, tail});
    write_reg(CFG_MAX_PAYLOAD, max_len);
    close_writes();
  endtask

  // Wait until every queued byte is taken and every expected result has come out.
  task automatic drain();
    while (bytes_taken != bytes_queued || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Byte sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  <= 1;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.rx_byte);
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          in_ch.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (byte_queue.size() != 0) begin
          in_ch.valid   <= 1'b1;
          in_ch.rx_byte <= byte_queue.pop_front();
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: ready follows a random pattern that is picked anew whenever its span runs out
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_mode   <= RDY_ALWAYS;
      ready_span   <= 0;
    end else begin
      if (ready_span == 0) begin
        ready_mode <= ready_mode_e'($urandom_range(0, 3));
        ready_span <= $urandom_range(16, 96);
      end else begin
        ready_span <= ready_span - 1;
      end
      case (ready_mode)
        RDY_ALWAYS: out_ch.ready <= 1'b1;
        RDY_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_ch.ready <= (ready_span % 4 == 0);
        default:    out_ch.ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_result.kind           = out_ch.kind;
      seen_result.payload_byte   = out_ch.payload_byte;
      seen_result.frame_order    = out_ch.frame_order;
      seen_result.payload_length = out_ch.payload_length;
      seen_result.verdict        = out_ch.verdict;
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result: expected none, actual 0x%0h", $time, seen_result);
        error_count++;
      end else begin
        due_result = expected_results.pop_front();
        check_field("kind", 16'(due_result.kind), 16'(seen_result.kind));
        check_field("payload_byte", 16'(due_result.payload_byte),
                    16'(seen_result.payload_byte));
        check_field("frame_order", 16'(due_result.frame_order),
                    16'(seen_result.frame_order));
        check_field("payload_length", due_result.payload_length,
                    seen_result.payload_length);
        check_field("verdict", 16'(due_result.verdict), 16'(seen_result.verdict));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [BYTE_W-1:0] mid_payload;
    logic [CRC_W-1:0]  mid_crc;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    bytes_queued  = 0;
    bytes_taken   = 0;
    error_count   = 0;
    cycle_count   = 0;
    reset_deframer();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: hunting noise, bad second header, length just under the minimum,
    // empty payload, CRC and tail both wrong, payload one over the limit, largest length.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(model_cfg.head_byte);
    send_byte(model_cfg.head_byte ^ 8'hFF);
    send_length_probe(16'd8);
    send_frame(FRAME_GOOD, 0, 8'hFF);
    send_frame(FRAME_BAD_BOTH, 1, 8'h00);
    send_length_probe(16'd1034);
    send_length_probe(16'hFFFF);
    random_traffic(80, 1'b1);
    drain();

    // Stop inside a frame, retarget the tail byte, then finish the frame
    mid_payload = 8'($urandom);
    mid_crc = crc16_next(CRC_INIT, mid_payload);
    send_byte(model_cfg.head_byte);
    send_byte(model_cfg.head_byte);
    send_byte(8'h00);
    send_byte(8'h0A);
    send_byte(8'($urandom));
    drain();
    write_reg(CFG_TAIL_BYTE, 16'($urandom_range(0, 255)));
    close_writes();
    send_byte(mid_payload);
    send_byte(mid_crc[15:8]);
    send_byte(mid_crc[7:0]);
    send_byte(model_cfg.tail_byte);
    send_byte(model_cfg.tail_byte);
    drain();

    apply_settings(8'h00, 8'hFF, 16'd0);
    random_traffic(80, 1'b0);
    drain();

    apply_settings(8'hFF, 8'h00, 16'd65526);
    send_frame(FRAME_GOOD, pick_payload_len(), 8'h5A);
    random_traffic(80, 1'b1);
    drain();

    apply_settings(8'($urandom), 8'($urandom), 16'($urandom_range(1, 200)));
    random_traffic(80, 1'b0);
    drain();

    apply_settings(8'($urandom), 8'($urandom), 16'd16);
    random_traffic(80, 1'b0);
    drain();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
